/* rtl/core/gpib_hs_pkg.sv */
// ----------------------------------------------------------------------------
// gpib_hs_pkg
// Shared types and constants for the three-wire handshake engine.
// ----------------------------------------------------------------------------
package gpib_hs_pkg;

   localparam int WAIT_BITS_DEFAULT = 16;
   localparam int LIMIT_W           = 16;
   localparam int BYTE_W            = 8;
   localparam int CSR_INDEX_W       = 3;
   localparam int CSR_DATA_W        = 16;

   localparam int REQ_DATA_W        = 24;
   localparam int RSP_DATA_W        = 32;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_TALK_LIMIT   = csr_index_type'(0);
   localparam csr_index_type CSR_LISTEN_LIMIT = csr_index_type'(1);
   localparam csr_index_type CSR_END_ON_LAST  = csr_index_type'(2);
   localparam csr_index_type CSR_APPEND_TERM  = csr_index_type'(3);
   localparam csr_index_type CSR_TERM_CHAR    = csr_index_type'(4);

   localparam logic [LIMIT_W-1:0] LIMIT_RESET     = LIMIT_W'(4687);
   localparam logic [BYTE_W-1:0]  TERM_CHAR_RESET = BYTE_W'(10);

   typedef enum logic [3:0] {
      PH_IDLE       = 4'd0,
      PH_T_NRFD     = 4'd1,
      PH_T_NDAC_REL = 4'd2,
      PH_T_NDAC     = 4'd3,
      PH_T_NEXT     = 4'd4,
      PH_L_DAV      = 4'd5,
      PH_L_DAV_REL  = 4'd6
   } phase_type;

   // one clock sample from host and bus
   typedef struct packed {
      logic              send_valid;
      logic [BYTE_W-1:0] send_data;
      logic              send_command;
      logic              send_final;
      logic              recv_start;
      logic              dav_sensed;
      logic              nrfd_sensed;
      logic              ndac_sensed;
      logic              eoi_sensed;
      logic [BYTE_W-1:0] bus_byte;
      logic              timer_tick;
   } sample_type;

   // line drives and host status after one sample
   typedef struct packed {
      logic              dav_drive;
      logic              nrfd_drive;
      logic              ndac_drive;
      logic              atn_drive;
      logic              eoi_drive;
      logic [BYTE_W-1:0] data_drive;
      logic              send_ready;
      logic              recv_valid;
      logic [BYTE_W-1:0] recv_data;
      logic              recv_last;
      logic              wait_expired;
      logic              engine_busy;
   } result_type;

endpackage

/* rtl/core/gpib_hs_core.sv */
// ----------------------------------------------------------------------------
// gpib_hs_core
// Handshake state machine, per-byte wait timer and configuration registers.
// State advances once per accepted sample; the result is combinational.
// ----------------------------------------------------------------------------
module gpib_hs_core #(
   parameter int WAIT_BITS = gpib_hs_pkg::WAIT_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  gpib_hs_pkg::csr_index_type        csr_index,
   input  logic [gpib_hs_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                              advance,
   input  gpib_hs_pkg::sample_type           sample,
   output gpib_hs_pkg::result_type           result
);

   localparam int CMP_W = (WAIT_BITS > gpib_hs_pkg::LIMIT_W) ? WAIT_BITS
                                                               : gpib_hs_pkg::LIMIT_W;

   // configuration
   logic [gpib_hs_pkg::LIMIT_W-1:0] talk_limit_ff;
   logic [gpib_hs_pkg::LIMIT_W-1:0] listen_limit_ff;
   logic                            end_on_last_ff;
   logic                            append_term_ff;
   logic [gpib_hs_pkg::BYTE_W-1:0]  term_char_ff;

   // transfer state
   gpib_hs_pkg::phase_type          phase_ff, phase_in;
   logic [WAIT_BITS-1:0]            cnt_ff, cnt_in;
   logic                            exp_ff, exp_in;
   logic [gpib_hs_pkg::BYTE_W-1:0]  held_ff, held_in;
   logic                            cmd_ff, cmd_in;
   logic                            fin_ff, fin_in;
   logic                            end_ff, end_in;

   logic                            talking;
   logic                            listening;
   logic [WAIT_BITS-1:0]            cnt_inc;
   logic [CMP_W-1:0]                cnt_cmp;
   logic [CMP_W-1:0]                lim_cmp;
   logic                            term_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         talk_limit_ff   <= gpib_hs_pkg::LIMIT_RESET;
         listen_limit_ff <= gpib_hs_pkg::LIMIT_RESET;
         end_on_last_ff  <= 1'b1;
         append_term_ff  <= 1'b0;
         term_char_ff    <= gpib_hs_pkg::TERM_CHAR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            gpib_hs_pkg::CSR_TALK_LIMIT:   talk_limit_ff   <= csr_wdata;
            gpib_hs_pkg::CSR_LISTEN_LIMIT: listen_limit_ff <= csr_wdata;
            gpib_hs_pkg::CSR_END_ON_LAST:  end_on_last_ff  <= csr_wdata[0];
            gpib_hs_pkg::CSR_APPEND_TERM:  append_term_ff  <= csr_wdata[0];
            gpib_hs_pkg::CSR_TERM_CHAR:    term_char_ff    <= csr_wdata[gpib_hs_pkg::BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= gpib_hs_pkg::PH_IDLE;
         cnt_ff   <= '0;
         exp_ff   <= 1'b0;
         held_ff  <= '0;
         cmd_ff   <= 1'b0;
         fin_ff   <= 1'b0;
         end_ff   <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         exp_ff   <= exp_in;
         held_ff  <= held_in;
         cmd_ff   <= cmd_in;
         fin_ff   <= fin_in;
         end_ff   <= end_in;
      end
   end

   always_comb begin
      talking   = (phase_ff == gpib_hs_pkg::PH_T_NRFD) ||
                  (phase_ff == gpib_hs_pkg::PH_T_NDAC_REL) ||
                  (phase_ff == gpib_hs_pkg::PH_T_NDAC);
      listening = (phase_ff == gpib_hs_pkg::PH_L_DAV) ||
                  (phase_ff == gpib_hs_pkg::PH_L_DAV_REL);

      // saturating tick counter, compared at the wider of the two widths
      cnt_inc = (cnt_ff == '1) ? cnt_ff : cnt_ff + WAIT_BITS'(1);
      cnt_cmp = CMP_W'(cnt_inc);
      lim_cmp = talking ? CMP_W'(talk_limit_ff) : CMP_W'(listen_limit_ff);

      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      exp_in   = exp_ff;
      held_in  = held_ff;
      cmd_in   = cmd_ff;
      fin_in   = fin_ff;
      end_in   = end_ff;
      term_out = 1'b0;

      result = '0;

      if ((talking || listening) && sample.timer_tick && !exp_ff) begin
         cnt_in = cnt_inc;
         if (cnt_cmp >= lim_cmp) begin
            exp_in = 1'b1;
         end
      end

      unique case (phase_ff)
         gpib_hs_pkg::PH_IDLE: begin
            result.send_ready = 1'b1;
            if (sample.send_valid) begin
               held_in  = sample.send_data;
               cmd_in   = sample.send_command;
               fin_in   = sample.send_final;
               cnt_in   = '0;
               exp_in   = 1'b0;
               phase_in = gpib_hs_pkg::PH_T_NRFD;
            end else if (sample.recv_start) begin
               cnt_in   = '0;
               exp_in   = 1'b0;
               end_in   = 1'b0;
               phase_in = gpib_hs_pkg::PH_L_DAV;
            end
         end
         gpib_hs_pkg::PH_T_NEXT: begin
            result.send_ready = 1'b1;
            if (sample.send_valid) begin
               held_in  = sample.send_data;
               fin_in   = sample.send_final;
               cnt_in   = '0;
               phase_in = gpib_hs_pkg::PH_T_NRFD;
            end
         end
         gpib_hs_pkg::PH_T_NRFD: begin
            if (exp_in || !sample.nrfd_sensed) phase_in = gpib_hs_pkg::PH_T_NDAC_REL;
         end
         gpib_hs_pkg::PH_T_NDAC_REL: begin
            if (exp_in || !sample.ndac_sensed) phase_in = gpib_hs_pkg::PH_T_NDAC;
         end
         gpib_hs_pkg::PH_T_NDAC: begin
            if (exp_in || sample.ndac_sensed) begin
               phase_in = fin_ff ? gpib_hs_pkg::PH_IDLE : gpib_hs_pkg::PH_T_NEXT;
            end
         end
         gpib_hs_pkg::PH_L_DAV: begin
            if (exp_in) begin
               phase_in = gpib_hs_pkg::PH_IDLE;
               term_out = append_term_ff;
            end else if (sample.dav_sensed) begin
               result.recv_valid = 1'b1;
               result.recv_data  = sample.bus_byte;
               result.recv_last  = sample.eoi_sensed && !append_term_ff;
               end_in            = sample.eoi_sensed;
               phase_in          = gpib_hs_pkg::PH_L_DAV_REL;
            end
         end
         gpib_hs_pkg::PH_L_DAV_REL: begin
            if (exp_in || !sample.dav_sensed) begin
               if (exp_in || end_ff) begin
                  phase_in = gpib_hs_pkg::PH_IDLE;
                  term_out = append_term_ff;
               end else begin
                  cnt_in   = '0;
                  phase_in = gpib_hs_pkg::PH_L_DAV;
               end
            end
         end
         default: phase_in = gpib_hs_pkg::PH_IDLE;
      endcase

      if (term_out) begin
         result.recv_valid = 1'b1;
         result.recv_data  = term_char_ff;
         result.recv_last  = 1'b1;
      end

      // line drives follow the phase after this sample
      unique case (phase_in)
         gpib_hs_pkg::PH_T_NRFD, gpib_hs_pkg::PH_T_NDAC_REL,
         gpib_hs_pkg::PH_T_NDAC, gpib_hs_pkg::PH_T_NEXT: begin
            result.data_drive = held_in;
            result.atn_drive  = cmd_in;
            result.dav_drive  = (phase_in == gpib_hs_pkg::PH_T_NDAC_REL);
            result.eoi_drive  = (phase_in != gpib_hs_pkg::PH_T_NEXT) && fin_in && !cmd_in &&
                                end_on_last_ff;
         end
         gpib_hs_pkg::PH_L_DAV:     result.ndac_drive = 1'b1;
         gpib_hs_pkg::PH_L_DAV_REL: result.nrfd_drive = 1'b1;
         default: ;
      endcase

      result.wait_expired = exp_in;
      result.engine_busy  = (phase_in != gpib_hs_pkg::PH_IDLE);
   end

endmodule

/* rtl/core/gpib_hs_out.sv */
// ----------------------------------------------------------------------------
// gpib_hs_out
// Result register: holds one result until the sink takes it and lets a
// new one in the same cycle the old one leaves.
// ----------------------------------------------------------------------------
module gpib_hs_out (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  gpib_hs_pkg::result_type result_in,
   output logic                    space,
   output logic                    rsp_valid,
   input  logic                    rsp_taken,
   output gpib_hs_pkg::result_type result_out
);

   logic                    valid_ff, valid_in;
   gpib_hs_pkg::result_type data_ff;

   always_comb begin
      space    = !valid_ff || rsp_taken;
      valid_in = load || (valid_ff && !rsp_taken);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign result_out = data_ff;

endmodule

/* rtl/core/gpib_handshake_engine.sv */
// ----------------------------------------------------------------------------
// gpib_handshake_engine
// IEEE 488 talker/listener three-wire handshake engine, one bus sample per
// transaction in, one line-drive/status result per transaction out.
//
//   channel  direction  handshake          payload
//   req      in         tvalid/tready      tdata, tuser=send_command, tlast=send_final
//   rsp      out        tvalid/tready      tdata, tlast=recv_last
//   csr      in         csr_we             csr_index, csr_wdata
//
// One sample is accepted per cycle while req_tready is high; its result appears in
// rsp in the next cycle, held in the single result register after the state machine.
// req_tready stays high while the result register is empty or being emptied,
// so a stalled rsp side holds req off after one result.
// After synchronous reset all lines are released and no result is pending.
// ----------------------------------------------------------------------------
module gpib_handshake_engine #(
   parameter int WAIT_BITS = gpib_hs_pkg::WAIT_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // send_valid, send_data[7:0], recv_start, dav_sensed, nrfd_sensed,
   // ndac_sensed, eoi_sensed, bus_byte[7:0], timer_tick, zero pad
   input  logic [gpib_hs_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                                req_tuser,   // send_command
   input  logic                                req_tlast,   // send_final
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // dav_drive, nrfd_drive, ndac_drive, atn_drive, eoi_drive, data_drive[7:0],
   // send_ready, recv_valid, recv_data[7:0], wait_expired, engine_busy, zero pad
   output logic [gpib_hs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                                rsp_tlast,   // recv_last
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_we,
   input  gpib_hs_pkg::csr_index_type          csr_index,
   input  logic [gpib_hs_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   gpib_hs_pkg::sample_type sample;
   gpib_hs_pkg::result_type step_result;
   gpib_hs_pkg::result_type held_result;
   logic                    space;
   logic                    accept;

   always_comb begin
      sample.send_valid   = req_tdata[0];
      sample.send_data    = req_tdata[8:1];
      sample.send_command = req_tuser;
      sample.send_final   = req_tlast;
      sample.recv_start   = req_tdata[9];
      sample.dav_sensed   = req_tdata[10];
      sample.nrfd_sensed  = req_tdata[11];
      sample.ndac_sensed  = req_tdata[12];
      sample.eoi_sensed   = req_tdata[13];
      sample.bus_byte     = req_tdata[21:14];
      sample.timer_tick   = req_tdata[22];
   end

   assign req_tready = space;
   assign accept     = req_tvalid && space;

   gpib_hs_core #(
      .WAIT_BITS (WAIT_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (accept),
      .sample    (sample),
      .result    (step_result)
   );

   gpib_hs_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .result_in  (step_result),
      .space      (space),
      .rsp_valid  (rsp_tvalid),
      .rsp_taken  (rsp_tready),
      .result_out (held_result)
   );

   assign rsp_tdata = {7'b0,
                       held_result.engine_busy,
                       held_result.wait_expired,
                       held_result.recv_data,
                       held_result.recv_valid,
                       held_result.send_ready,
                       held_result.data_drive,
                       held_result.eoi_drive,
                       held_result.atn_drive,
                       held_result.ndac_drive,
                       held_result.nrfd_drive,
                       held_result.dav_drive};
   assign rsp_tlast = held_result.recv_last;

   // a full, stalled result register must hold off new samples
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("sample accepted while result register stalled");

   // no received data or last mark without recv_valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !held_result.recv_valid |->
         held_result.recv_data == '0 && !rsp_tlast)
      else $error("recv fields set without recv_valid");

   // talker and listener drives never overlap
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (held_result.dav_drive || held_result.atn_drive) |->
         !held_result.nrfd_drive && !held_result.ndac_drive)
      else $error("talker and listener lines driven together");

   // when not busy every line is released
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !held_result.engine_busy |->
         !held_result.dav_drive && !held_result.nrfd_drive && !held_result.ndac_drive &&
         !held_result.atn_drive && !held_result.eoi_drive && held_result.data_drive == '0)
      else $error("lines driven while idle");

endmodule
